// ===== rtl/ttbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttbd_pkg
// Shared types and codes for the tagged token byte decoder.
// ----------------------------------------------------------------------------
package ttbd_pkg;

   localparam int BYTE_W   = 8;
   localparam int INT_W    = 32;
   localparam int LEN_W    = 9;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 8;

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] REG_INTEGER_TAG      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRING_OPEN_TAG  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRING_CLOSE_TAG = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MESSAGE_END_TAG  = 8'd3;

   // Reset values of the tag registers
   localparam logic [BYTE_W-1:0] RST_INTEGER_TAG      = 8'd1;
   localparam logic [BYTE_W-1:0] RST_STRING_OPEN_TAG  = 8'd2;
   localparam logic [BYTE_W-1:0] RST_STRING_CLOSE_TAG = 8'd3;
   localparam logic [BYTE_W-1:0] RST_MESSAGE_END_TAG  = 8'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_RUNNING  = 2'd0,
      ST_INT_DONE = 2'd1,
      ST_STR_DONE = 2'd2,
      ST_MSG_END  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] integer_tag;
      logic [BYTE_W-1:0] string_open_tag;
      logic [BYTE_W-1:0] string_close_tag;
      logic [BYTE_W-1:0] message_end_tag;
   } tags_type;

endpackage

// ===== rtl/ttbd_if.sv =====
// ----------------------------------------------------------------------------
// ttbd channel interfaces
// Valid/ready channels for input bytes, decoded results and register writes.
// ----------------------------------------------------------------------------
interface ttbd_req_if;
   logic                          valid;
   logic                          ready;
   logic [ttbd_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ttbd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ttbd_pkg::STATUS_W-1:0]   status;
   logic signed [ttbd_pkg::INT_W-1:0] integer_value;
   logic [ttbd_pkg::LEN_W-1:0]      text_length;
   logic                            char_valid;
   logic [ttbd_pkg::BYTE_W-1:0]     char_value;
   logic [ttbd_pkg::POS_W-1:0]      char_position;

   modport source (output valid, output status, output integer_value, output text_length,
                   output char_valid, output char_value, output char_position,
                   input ready);
   modport sink   (input valid, input status, input integer_value, input text_length,
                   input char_valid, input char_value, input char_position,
                   output ready);
endinterface

interface ttbd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ttbd_pkg::CSR_IDX_W-1:0]   index;
   logic [ttbd_pkg::BYTE_W-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/ttbd_csr.sv =====
// ----------------------------------------------------------------------------
// ttbd_csr
// Tag register file, written one beat at a time over the configuration channel.
// ----------------------------------------------------------------------------
module ttbd_csr (
   input  logic               clock,
   input  logic               reset,
   ttbd_csr_if.sink           csr_bus,
   output ttbd_pkg::tags_type tags
);

   ttbd_pkg::tags_type tags_ff;
   ttbd_pkg::tags_type tags_in;

   assign csr_bus.ready = 1'b1;
   assign tags          = tags_ff;

   always_comb begin
      tags_in = tags_ff;
      if (csr_bus.valid) begin
         // writes beyond the register list are dropped
         unique case (csr_bus.index)
            ttbd_pkg::REG_INTEGER_TAG:      tags_in.integer_tag      = csr_bus.wdata;
            ttbd_pkg::REG_STRING_OPEN_TAG:  tags_in.string_open_tag  = csr_bus.wdata;
            ttbd_pkg::REG_STRING_CLOSE_TAG: tags_in.string_close_tag = csr_bus.wdata;
            ttbd_pkg::REG_MESSAGE_END_TAG:  tags_in.message_end_tag  = csr_bus.wdata;
            default:                        tags_in = tags_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tags_ff.integer_tag      <= ttbd_pkg::RST_INTEGER_TAG;
         tags_ff.string_open_tag  <= ttbd_pkg::RST_STRING_OPEN_TAG;
         tags_ff.string_close_tag <= ttbd_pkg::RST_STRING_CLOSE_TAG;
         tags_ff.message_end_tag  <= ttbd_pkg::RST_MESSAGE_END_TAG;
      end else begin
         tags_ff <= tags_in;
      end
   end

endmodule

// ===== rtl/ttbd_dec.sv =====
// ----------------------------------------------------------------------------
// ttbd_dec
// Input byte register, token decode state and result register.
// ----------------------------------------------------------------------------
module ttbd_dec #(
   parameter int MAX_TEXT_LEN = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  ttbd_pkg::tags_type tags,
   ttbd_req_if.sink           req_bus,
   ttbd_rsp_if.source         rsp_bus
);

   localparam int CNT_W = $clog2(MAX_TEXT_LEN + 1);
   localparam int EXT_W = CNT_W + ttbd_pkg::LEN_W;

   typedef enum logic [2:0] {
      PH_TYPE = 3'd0,
      PH_INT0 = 3'd1,
      PH_INT1 = 3'd2,
      PH_INT2 = 3'd3,
      PH_INT3 = 3'd4,
      PH_STR  = 3'd5
   } phase_type;

   // input stage
   logic                         in_valid_ff;
   logic [ttbd_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                         advance;

   // decode state
   phase_type                    phase_ff, phase_in;
   logic [ttbd_pkg::INT_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [EXT_W-1:0]             cnt_ext;
   logic [ttbd_pkg::INT_W-1:0]   acc_shift;

   // result stage
   logic                         out_valid_ff;
   ttbd_pkg::status_type         status_ff, status_in;
   logic [ttbd_pkg::INT_W-1:0]   ival_ff, ival_in;
   logic [ttbd_pkg::LEN_W-1:0]   tlen_ff, tlen_in;
   logic                         cvalid_ff, cvalid_in;
   logic [ttbd_pkg::BYTE_W-1:0]  cval_ff, cval_in;
   logic [ttbd_pkg::POS_W-1:0]   cpos_ff, cpos_in;

   // move a held byte on when the result register is free or being drained
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   assign cnt_ext   = {{ttbd_pkg::LEN_W{1'b0}}, cnt_ff};
   assign acc_shift = {acc_ff[ttbd_pkg::INT_W-ttbd_pkg::BYTE_W-1:0], in_byte_ff};

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      status_in = ttbd_pkg::ST_RUNNING;
      ival_in   = '0;
      tlen_in   = '0;
      cvalid_in = 1'b0;
      cval_in   = '0;
      cpos_in   = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            // integer tag wins over string open, string open over message end
            if (in_byte_ff == tags.integer_tag) begin
               phase_in = PH_INT0;
               acc_in   = '0;
            end else if (in_byte_ff == tags.string_open_tag) begin
               phase_in = PH_STR;
               cnt_in   = '0;
            end else if (in_byte_ff == tags.message_end_tag) begin
               status_in = ttbd_pkg::ST_MSG_END;
            end
         end
         PH_INT0: begin
            acc_in   = acc_shift;
            phase_in = PH_INT1;
         end
         PH_INT1: begin
            acc_in   = acc_shift;
            phase_in = PH_INT2;
         end
         PH_INT2: begin
            acc_in   = acc_shift;
            phase_in = PH_INT3;
         end
         PH_INT3: begin
            acc_in    = acc_shift;
            phase_in  = PH_TYPE;
            status_in = ttbd_pkg::ST_INT_DONE;
            ival_in   = acc_shift;
         end
         PH_STR: begin
            if (in_byte_ff != tags.string_close_tag) begin
               // drop characters once the string is full
               if (cnt_ff < CNT_W'(MAX_TEXT_LEN)) begin
                  cvalid_in = 1'b1;
                  cval_in   = in_byte_ff;
                  cpos_in   = cnt_ext[ttbd_pkg::POS_W-1:0];
                  cnt_in    = cnt_ff + 1'b1;
               end
            end else begin
               phase_in  = PH_TYPE;
               status_in = ttbd_pkg::ST_STR_DONE;
               tlen_in   = cnt_ext[ttbd_pkg::LEN_W-1:0];
            end
         end
         default: phase_in = PH_TYPE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_TYPE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            acc_ff       <= acc_in;
            cnt_ff       <= cnt_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data_byte;
      end
      if (advance) begin
         status_ff <= status_in;
         ival_ff   <= ival_in;
         tlen_ff   <= tlen_in;
         cvalid_ff <= cvalid_in;
         cval_ff   <= cval_in;
         cpos_ff   <= cpos_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.integer_value = ival_ff;
   assign rsp_bus.text_length   = tlen_ff;
   assign rsp_bus.char_valid    = cvalid_ff;
   assign rsp_bus.char_value    = cval_ff;
   assign rsp_bus.char_position = cpos_ff;

endmodule

// ===== rtl/tagged_token_byte_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tagged_token_byte_decoder_unit
// Decodes a byte stream of tagged integers, strings and end-of-message marks.
// ----------------------------------------------------------------------------
//  channel   dir  beat carries
//  req_bus   in   data_byte
//  rsp_bus   out  status, integer_value, text_length, char_valid/value/position
//  csr_bus   in   index, wdata (tag registers 0..3)
//
//  One byte per cycle sustained while rsp_bus is ready; each byte passes
//  through the input register, then the result register, which presents
//  its result beat. The token state update is one short step between those
//  two registers. A stalled rsp_bus holds the result; one more byte is held
//  in the input register before req_bus.ready drops.
//  Synchronous reset restores the default tags and the wait-for-type state.
// ----------------------------------------------------------------------------
module tagged_token_byte_decoder_unit #(
   parameter int MAX_TEXT_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   ttbd_req_if.sink   req_bus,
   ttbd_rsp_if.source rsp_bus,
   ttbd_csr_if.sink   csr_bus
);

   ttbd_pkg::tags_type tags;

   ttbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .tags    (tags)
   );

   ttbd_dec #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_dec (
      .clock   (clock),
      .reset   (reset),
      .tags    (tags),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== sim/tb_tagged_token_byte_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tagged_token_byte_decoder_unit
// Self-checking bench: drives byte beats through a directed token table and
// then random token streams under several tag settings, predicts each result
// beat in the bench and compares it field by field, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_tagged_token_byte_decoder_unit;

   localparam int TEXT_LIMIT    = 256;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 24;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_ROWS = 26;

   // Indexes past the register list; writes to them must change nothing
   localparam logic [ttbd_pkg::CSR_IDX_W-1:0] REG_UNMAPPED_LOW = 8'd4;
   localparam logic [ttbd_pkg::CSR_IDX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

   typedef enum logic [2:0] {
      TOK_TYPE, TOK_INT0, TOK_INT1, TOK_INT2, TOK_INT3, TOK_STRING
   } token_phase_type;

   typedef struct packed {
      ttbd_pkg::status_type status;
      logic signed [31:0]   integer_value;
      logic [8:0]           text_length;
      logic                 char_valid;
      logic [7:0]           char_value;
      logic [7:0]           char_position;
   } decode_result_type;

   typedef struct packed {
      logic [7:0]        data;
      logic              typed;
      decode_result_type res;
   } stim_row_type;

   logic clock;
   logic reset;

   ttbd_req_if req_bus ();
   ttbd_rsp_if rsp_bus ();
   ttbd_csr_if csr_bus ();

   tagged_token_byte_decoder_unit #(.MAX_TEXT_LEN(TEXT_LIMIT)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Decoder state as the bench sees it
   ttbd_pkg::tags_type active_tags = {ttbd_pkg::RST_INTEGER_TAG,
                                      ttbd_pkg::RST_STRING_OPEN_TAG,
                                      ttbd_pkg::RST_STRING_CLOSE_TAG,
                                      ttbd_pkg::RST_MESSAGE_END_TAG};
   token_phase_type    tok_phase = TOK_TYPE;
   logic [31:0]        int_acc = '0;
   int unsigned        text_count = 0;

   decode_result_type pending_results [$];
   stim_row_type      directed_rows [DIRECTED_ROWS];
   int                error_count = 0;
   int                byte_count = 0;
   int                cycle_count = 0;
   logic              req_idle_off = 1'b0;
   logic              rsp_idle_off = 1'b0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_tagged_token_byte_decoder_unit: FAIL");
         $finish;
      end
   end

   function automatic decode_result_type make_result(input ttbd_pkg::status_type s,
                                                     input logic [31:0] iv,
                                                     input logic [8:0] len,
                                                     input logic cv,
                                                     input logic [7:0] cval,
                                                     input logic [7:0] cpos);
      decode_result_type r;
      r.status        = s;
      r.integer_value = iv;
      r.text_length   = len;
      r.char_valid    = cv;
      r.char_value    = cval;
      r.char_position = cpos;
      return r;
   endfunction

   // Advance the token state by one byte and give the result beat it causes
   task automatic decode_byte(input logic [7:0] value, output decode_result_type r);
      r = make_result(ttbd_pkg::ST_RUNNING, '0, '0, 1'b0, '0, '0);
      case (tok_phase)
         TOK_TYPE: begin
            if (value == active_tags.integer_tag) begin
               tok_phase = TOK_INT0;
               int_acc   = '0;
            end else if (value == active_tags.string_open_tag) begin
               tok_phase  = TOK_STRING;
               text_count = 0;
            end else if (value == active_tags.message_end_tag) begin
               r.status = ttbd_pkg::ST_MSG_END;
            end
         end
         TOK_INT0, TOK_INT1, TOK_INT2: begin
            int_acc   = {int_acc[23:0], value};
            tok_phase = token_phase_type'(tok_phase + 3'd1);
         end
         TOK_INT3: begin
            int_acc         = {int_acc[23:0], value};
            tok_phase       = TOK_TYPE;
            r.status        = ttbd_pkg::ST_INT_DONE;
            r.integer_value = int_acc;
         end
         TOK_STRING: begin
            if (value != active_tags.string_close_tag) begin
               // drop characters once the string is full
               if (text_count < TEXT_LIMIT) begin
                  r.char_valid    = 1'b1;
                  r.char_value    = value;
                  r.char_position = text_count[7:0];
                  text_count      = text_count + 1;
               end
            end else begin
               tok_phase     = TOK_TYPE;
               r.status      = ttbd_pkg::ST_STR_DONE;
               r.text_length = text_count[8:0];
            end
         end
         default: tok_phase = TOK_TYPE;
      endcase
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h",
                  $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      decode_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result beat with none expected, got status %0d",
                     $time, rsp_bus.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("integer_value", want.integer_value, rsp_bus.integer_value);
            check_field("text_length", want.text_length, rsp_bus.text_length);
            check_field("char_valid", want.char_valid, rsp_bus.char_valid);
            check_field("char_value", want.char_value, rsp_bus.char_value);
            check_field("char_position", want.char_position, rsp_bus.char_position);
         end
      end
   end

   // Result side: drop ready for a random stall before each beat unless rsp_idle_off is set
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_idle_off ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat
   task automatic send_byte(input logic [7:0] value, input logic typed,
                            input decode_result_type typed_res);
      int gap;
      decode_result_type predicted;
      gap = req_idle_off ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      decode_byte(value, predicted);
      pending_results.push_back(typed ? typed_res : predicted);
      byte_count++;
      @(negedge clock);
   endtask

   task automatic send_data(input logic [7:0] value);
      send_byte(value, 1'b0, '0);
   endtask

   task automatic send_string(input int n, input logic closed);
      int k;
      logic [7:0] c;
      send_data(active_tags.string_open_tag);
      for (k = 0; k < n; k++) begin
         do begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, 7));
         end while (c == active_tags.string_close_tag);
         send_data(c);
      end
      if (closed)
         send_data(active_tags.string_close_tag);
   endtask

   task automatic send_random_token();
      int pick;
      int k;
      int n;
      logic [31:0] word;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         case ($urandom_range(0, 7))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'h8000_0000;
            3:       word = 32'h7FFF_FFFF;
            4:       word = active_tags;
            default: word = $urandom;
         endcase
         send_data(active_tags.integer_tag);
         for (k = 3; k >= 0; k--)
            send_data(word[8*k +: 8]);
      end else if (pick < 70) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         send_string(n, 1'b1);
      end else if (pick < 82) begin
         send_data(active_tags.message_end_tag);
      end else if (pick < 94) begin
         send_data(8'($urandom_range(0, 255)));
      end else begin
         // broken string: leave it open, later bytes become characters
         send_string($urandom_range(0, 5), 1'b0);
      end
   endtask

   task automatic write_register(input logic [ttbd_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         ttbd_pkg::REG_INTEGER_TAG:      active_tags.integer_tag      = value;
         ttbd_pkg::REG_STRING_OPEN_TAG:  active_tags.string_open_tag  = value;
         ttbd_pkg::REG_STRING_CLOSE_TAG: active_tags.string_close_tag = value;
         ttbd_pkg::REG_MESSAGE_END_TAG:  active_tags.message_end_tag  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int p;
      int r;
      int phase_start;
      ttbd_pkg::tags_type next_tags;
      decode_result_type quiet;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.wdata     = '0;

      quiet = make_result(ttbd_pkg::ST_RUNNING, '0, '0, 1'b0, '0, '0);
      directed_rows = '{
         '{8'h00, 1'b1, quiet},
         '{8'hFF, 1'b1, quiet},
         '{ttbd_pkg::RST_MESSAGE_END_TAG, 1'b1,
           make_result(ttbd_pkg::ST_MSG_END, '0, '0, 1'b0, '0, '0)},
         '{ttbd_pkg::RST_INTEGER_TAG, 1'b1, quiet},
         '{8'h80, 1'b1, quiet},
         '{8'h00, 1'b1, quiet},
         '{8'h00, 1'b1, quiet},
         '{8'h00, 1'b1,
           make_result(ttbd_pkg::ST_INT_DONE, 32'h8000_0000, '0, 1'b0, '0, '0)},
         '{ttbd_pkg::RST_INTEGER_TAG, 1'b0, quiet},
         '{8'h7F, 1'b0, quiet},
         '{8'hFF, 1'b0, quiet},
         '{8'hFF, 1'b0, quiet},
         '{8'hFF, 1'b1,
           make_result(ttbd_pkg::ST_INT_DONE, 32'h7FFF_FFFF, '0, 1'b0, '0, '0)},
         // tag values inside an integer are plain data
         '{ttbd_pkg::RST_INTEGER_TAG, 1'b0, quiet},
         '{ttbd_pkg::RST_INTEGER_TAG, 1'b0, quiet},
         '{ttbd_pkg::RST_STRING_OPEN_TAG, 1'b0, quiet},
         '{ttbd_pkg::RST_STRING_CLOSE_TAG, 1'b0, quiet},
         '{ttbd_pkg::RST_MESSAGE_END_TAG, 1'b1,
           make_result(ttbd_pkg::ST_INT_DONE, 32'h0102_0304, '0, 1'b0, '0, '0)},
         '{ttbd_pkg::RST_STRING_OPEN_TAG, 1'b1, quiet},
         '{ttbd_pkg::RST_STRING_CLOSE_TAG, 1'b1,
           make_result(ttbd_pkg::ST_STR_DONE, '0, 9'd0, 1'b0, '0, '0)},
         '{ttbd_pkg::RST_STRING_OPEN_TAG, 1'b0, quiet},
         '{8'hFF, 1'b1, make_result(ttbd_pkg::ST_RUNNING, '0, '0, 1'b1, 8'hFF, 8'd0)},
         '{8'h00, 1'b1, make_result(ttbd_pkg::ST_RUNNING, '0, '0, 1'b1, 8'h00, 8'd1)},
         '{ttbd_pkg::RST_INTEGER_TAG, 1'b1,
           make_result(ttbd_pkg::ST_RUNNING, '0, '0, 1'b1, 8'h01, 8'd2)},
         '{ttbd_pkg::RST_MESSAGE_END_TAG, 1'b0, quiet},
         '{ttbd_pkg::RST_STRING_CLOSE_TAG, 1'b1,
           make_result(ttbd_pkg::ST_STR_DONE, '0, 9'd4, 1'b0, '0, '0)}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (r = 0; r < DIRECTED_ROWS; r++)
         send_byte(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].res);

      for (p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            // hold off until every result beat is back before touching the tags
            wait_drained();
            case (p)
               1: next_tags = {8'h00, 8'hFF, 8'h80, 8'h7F};
               2: next_tags = {8'hFF, 8'h00, 8'h7F, 8'h80};
               // open tag equals end tag: open wins
               3: next_tags = {8'h10, 8'h20, 8'h10, 8'h20};
               // integer, open and end tags equal: integer wins
               4: next_tags = {8'h55, 8'h55, 8'hAA, 8'h55};
               5: next_tags = $urandom;
               default: next_tags = {ttbd_pkg::RST_INTEGER_TAG,
                                     ttbd_pkg::RST_STRING_OPEN_TAG,
                                     ttbd_pkg::RST_STRING_CLOSE_TAG,
                                     ttbd_pkg::RST_MESSAGE_END_TAG};
            endcase
            write_register(ttbd_pkg::REG_INTEGER_TAG, next_tags.integer_tag);
            write_register(ttbd_pkg::REG_STRING_OPEN_TAG, next_tags.string_open_tag);
            write_register(ttbd_pkg::REG_STRING_CLOSE_TAG, next_tags.string_close_tag);
            write_register(ttbd_pkg::REG_MESSAGE_END_TAG, next_tags.message_end_tag);
            if (p == 3) begin
               write_register(REG_UNMAPPED_LOW, 8'hFF);
               write_register(REG_UNMAPPED_TOP, 8'h00);
            end
         end
         req_idle_off = p[0];
         rsp_idle_off = p[1];
         // overflow past the limit once, and fill it exactly once
         if (p == 0)
            send_string(TEXT_LIMIT + $urandom_range(1, 12), 1'b1);
         if (p == 1)
            send_string(TEXT_LIMIT, 1'b1);
         phase_start = byte_count;
         while (byte_count - phase_start < PHASE_ITEMS)
            send_random_token();
         // close any open token so the next phase starts at a type byte
         while (tok_phase != TOK_TYPE)
            send_data(tok_phase == TOK_STRING ? active_tags.string_close_tag
                                              : 8'($urandom_range(0, 255)));
      end

      wait_drained();
      if (error_count == 0)
         $display("tb_tagged_token_byte_decoder_unit: PASS");
      else
         $display("tb_tagged_token_byte_decoder_unit: FAIL");
      $finish;
   end

endmodule
